### hw/rtl/wspt_pkg.sv
// Shared types and constants for the working-set page tracker.
// No dependencies; used by the controller, the datapath and the top level.
package wspt_pkg;

	localparam int PAGE_IN_W   = 16;
	localparam int WINDOW_W    = 6;
	localparam int RES_CNT_W   = 7;
	localparam int FAULT_CNT_W = 32;
	localparam int STAMP_W     = 32;
	localparam int S_TDATA_W   = 16;
	localparam int M_TDATA_W   = 40;
	localparam int GROUP_W     = 32;
	localparam int GSUM_W      = 6;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 6'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_SCAN,
		ST_REPLACE,
		ST_COUNT,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic lookup;
		logic scan;
		logic replace;
		logic count;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic full_miss;
		logic scan_last;
		logic out_free;
	} dp_status_t;

endpackage

### hw/rtl/wspt_ctrl.sv
// Sequencing controller of the working-set page tracker.
// Depends on wspt_pkg; drives the datapath through dp_cmd_t, reads dp_status_t.
module wspt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  wspt_pkg::dp_status_t sts,
	output wspt_pkg::dp_cmd_t    cmd
);

	wspt_pkg::ctrl_state_t state_q;
	wspt_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wspt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			wspt_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = wspt_pkg::ST_LOOKUP;
				end
			end
			wspt_pkg::ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = sts.full_miss ? wspt_pkg::ST_SCAN : wspt_pkg::ST_COUNT;
			end
			wspt_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = wspt_pkg::ST_REPLACE;
				end
			end
			wspt_pkg::ST_REPLACE: begin
				cmd.replace = 1'b1;
				state_d     = wspt_pkg::ST_COUNT;
			end
			wspt_pkg::ST_COUNT: begin
				cmd.count = 1'b1;
				state_d   = wspt_pkg::ST_EMIT;
			end
			wspt_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = wspt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wspt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/wspt_dp.sv
// Datapath of the working-set page tracker: entry table, counters, oldest scan,
// resident popcount and output register. Depends on wspt_pkg.
module wspt_dp #(
	parameter int ENTRIES   = 64,
	parameter int PAGE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [wspt_pkg::S_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [wspt_pkg::M_TDATA_W-1:0]      m_tdata,
	input  logic                                cfg_wr_en,
	input  logic [wspt_pkg::WINDOW_W-1:0]       cfg_wr_data,
	input  wspt_pkg::dp_cmd_t                   cmd,
	output wspt_pkg::dp_status_t                sts
);

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int GROUPS = (ENTRIES + wspt_pkg::GROUP_W - 1) / wspt_pkg::GROUP_W;
	localparam int PAD_W  = GROUPS * wspt_pkg::GROUP_W;

	logic [PAGE_BITS-1:0]              entry_page_q  [ENTRIES];
	logic [wspt_pkg::STAMP_W-1:0]      entry_stamp_q [ENTRIES];
	logic [ENTRIES-1:0]                valid_q;
	logic [PAGE_BITS-1:0]              page_in_q;
	logic [wspt_pkg::STAMP_W-1:0]      pos_q;
	logic [wspt_pkg::FAULT_CNT_W-1:0]  faults_q;
	logic [wspt_pkg::WINDOW_W-1:0]     window_q;
	logic                              fault_q;
	logic [IDX_W-1:0]                  scan_idx_q;
	logic [IDX_W-1:0]                  best_idx_q;
	logic [wspt_pkg::STAMP_W-1:0]      best_age_q;
	logic [wspt_pkg::GSUM_W-1:0]       gsum_s1 [GROUPS];
	logic                              out_valid_q;
	logic [wspt_pkg::M_TDATA_W-1:0]    out_data_q;

	logic [ENTRIES-1:0]                hit_vec;
	logic [ENTRIES-1:0]                expire;
	logic [ENTRIES-1:0]                valid_ev;
	logic [ENTRIES-1:0]                free_vec;
	logic [ENTRIES-1:0]                free_oh;
	logic [ENTRIES-1:0]                repl_oh;
	logic [ENTRIES-1:0]                page_we;
	logic [ENTRIES-1:0]                stamp_we;
	logic                              hit;
	logic                              full;
	logic [wspt_pkg::STAMP_W-1:0]      scan_age;
	logic [PAD_W-1:0]                  valid_pad;
	logic [CNT_W-1:0]                  total;
	logic                              out_free;

	// per-entry tag match and age check
	always_comb begin
		for (int k = 0; k < ENTRIES; k++) begin
			hit_vec[k] = valid_q[k] && (entry_page_q[k] == page_in_q);
			expire[k]  = valid_q[k] &&
				((pos_q - entry_stamp_q[k]) > wspt_pkg::STAMP_W'(window_q));
		end
	end

	assign hit      = |hit_vec;
	assign valid_ev = valid_q & ~expire;
	assign free_vec = ~valid_ev;
	assign free_oh  = free_vec & (~free_vec + ENTRIES'(1));
	assign full     = ~|free_vec;
	assign repl_oh  = ENTRIES'(1) << best_idx_q;
	assign scan_age = pos_q - entry_stamp_q[scan_idx_q];

	always_comb begin
		page_we  = '0;
		stamp_we = '0;
		if (cmd.lookup) begin
			if (hit) begin
				stamp_we = hit_vec;
			end else if (!full) begin
				page_we  = free_oh;
				stamp_we = free_oh;
			end
		end else if (cmd.replace) begin
			page_we  = repl_oh;
			stamp_we = repl_oh;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < ENTRIES; k++) begin
			if (page_we[k]) begin
				entry_page_q[k] <= page_in_q;
			end
			if (stamp_we[k]) begin
				entry_stamp_q[k] <= pos_q + wspt_pkg::STAMP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_in_q <= PAGE_BITS'(s_tdata);
		end
		if (cmd.lookup) begin
			fault_q    <= !hit;
			scan_idx_q <= '0;
		end
		if (cmd.scan) begin
			scan_idx_q <= scan_idx_q + IDX_W'(1);
			if (scan_idx_q == '0 || scan_age > best_age_q) begin
				best_idx_q <= scan_idx_q;
				best_age_q <= scan_age;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			pos_q    <= '0;
			faults_q <= '0;
			window_q <= wspt_pkg::WINDOW_RESET;
		end else begin
			if (cfg_wr_en) begin
				window_q <= cfg_wr_data;
			end
			if (cmd.lookup) begin
				if (hit) begin
					pos_q <= pos_q + wspt_pkg::STAMP_W'(1);
				end else if (!full) begin
					valid_q  <= valid_ev | free_oh;
					pos_q    <= pos_q + wspt_pkg::STAMP_W'(1);
					faults_q <= faults_q + wspt_pkg::FAULT_CNT_W'(1);
				end
			end else if (cmd.replace) begin
				pos_q    <= pos_q + wspt_pkg::STAMP_W'(1);
				faults_q <= faults_q + wspt_pkg::FAULT_CNT_W'(1);
			end
		end
	end

	// resident count: group popcounts registered, then summed
	assign valid_pad = PAD_W'(valid_q);

	always_ff @(posedge clk) begin
		if (cmd.count) begin
			for (int g = 0; g < GROUPS; g++) begin
				gsum_s1[g] <= wspt_pkg::GSUM_W'(
					$countones(valid_pad[g*wspt_pkg::GROUP_W +: wspt_pkg::GROUP_W]));
			end
		end
	end

	always_comb begin
		total = '0;
		for (int g = 0; g < GROUPS; g++) begin
			total = total + CNT_W'(gsum_s1[g]);
		end
	end

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= {faults_q, wspt_pkg::RES_CNT_W'(total), fault_q};
		end
	end

	assign m_tvalid      = out_valid_q;
	assign m_tdata       = out_data_q;
	assign sts.full_miss = !hit && full;
	assign sts.scan_last = (scan_idx_q == IDX_W'(ENTRIES - 1));
	assign sts.out_free  = out_free;

endmodule

### hw/rtl/working_set_page_tracker.sv
// Top level of the working-set page tracker.
// Depends on wspt_pkg, wspt_ctrl and wspt_dp.
//
// One page reference per item, one result per item. A hit or a miss that finds
// a free entry (after expiring pages idle longer than the window) passes through
// acceptance, the lookup, the registered resident popcount and the output load,
// which waits for a free output register, before the next item is accepted. A
// miss with the table full and nothing expired adds a scan for the oldest entry,
// one entry per cycle, and then a replace step. The output register lets a
// result wait on m_tready while the next item is accepted; the window register
// resets to 4.
module working_set_page_tracker #(
	parameter int ENTRIES   = 64,
	parameter int PAGE_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [wspt_pkg::S_TDATA_W-1:0]     s_tdata,     // [15:0] page_number
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [wspt_pkg::M_TDATA_W-1:0]     m_tdata,     // [0] fault, [7:1] resident_count,
	                                                        // [39:8] fault_count
	input  logic                               cfg_wr_en,
	input  logic [wspt_pkg::WINDOW_W-1:0]      cfg_wr_data  // window
);

	wspt_pkg::dp_cmd_t    cmd;
	wspt_pkg::dp_status_t sts;

	wspt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wspt_dp #(
		.ENTRIES   (ENTRIES),
		.PAGE_BITS (PAGE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

### hw/rtl/wspt_checker.sv
// Port-level checks for the working-set page tracker, bound to the top level.
// Depends on wspt_pkg.
module wspt_checker #(
	parameter int ENTRIES = 64
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [wspt_pkg::M_TDATA_W-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while previous item in work");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (ENTRIES > 127) ||
			(m_tdata[7:1] != 7'd0 && m_tdata[7:1] <= 7'(ENTRIES)))
		else $error("resident count out of range");

	a_ready_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("not ready after producing result");

endmodule

bind working_set_page_tracker wspt_checker #(.ENTRIES(ENTRIES)) u_wspt_checker (.*);
